[sv/sbb_pkg.sv]
// ----------------------------------------------------------------------------
// sbb_pkg: shared types and constants for the separable box blur
// Sizes of the line store, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package sbb_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_KERNEL  = 31;

    localparam int DIM_W       = 11;                  // width / height registers
    localparam int COL_W       = $clog2(MAX_WIDTH);   // column index
    localparam int ROW_W       = $clog2(MAX_HEIGHT) + 1;
    localparam int KER_W       = 5;                   // kernel size
    localparam int HALF_W      = KER_W - 1;
    localparam int RING_W      = $clog2(MAX_KERNEL);
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 13;                  // 31 * 255 fits
    localparam int POS_W       = 12;                  // signed window position
    localparam int LINE_DEPTH  = MAX_KERNEL * MAX_WIDTH;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_KERNEL_WIDTH  = 2'd2,
        REG_KERNEL_HEIGHT = 2'd3
    } t_cfg_reg;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   num;
        logic [KER_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [PIX_W-1:0]   quo;
    } t_div_rsp;

endpackage

[sv/separable_box_blur.sv]
// ----------------------------------------------------------------------------
// separable_box_blur: box blur with replicated borders over a pixel stream
// Per item: a pixel item may compute one horizontal result (up to pw+1 at the
// end of a row), then any item may compute one vertical result when its window
// is complete; both share the one divider, and vertical sums read the line store.
// One item is in work at a time; the output register frees the input side.
// Reset (synchronous, active low) restores 1024x1024, 3x3 and a fresh frame.
// ----------------------------------------------------------------------------
module separable_box_blur (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sbb_pkg::PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_in
    input  logic                          s_axis_tuser,   // [0] req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sbb_pkg::PIX_W-1:0]     m_axis_tdata,   // [7:0] pixel_out
    output logic                          m_axis_tlast,   // frame_last
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sbb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbb_pkg::DIM_W-1:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_HSTART, S_HSUM, S_HGO, S_HDIV,
        S_VCHECK, S_VRD, S_VLAST, S_VGO, S_VDIV, S_PUT
    } t_state;

    typedef sbb_pkg::t_cfg_reg t_cfg_sel;

    localparam int COL_W  = sbb_pkg::COL_W;
    localparam int ROW_W  = sbb_pkg::ROW_W;
    localparam int RING_W = sbb_pkg::RING_W;
    localparam int POS_W  = sbb_pkg::POS_W;
    localparam int KER_W  = sbb_pkg::KER_W;
    localparam int SUM_W  = sbb_pkg::SUM_W;
    localparam int DIM_W  = sbb_pkg::DIM_W;
    localparam logic [RING_W-1:0] WIN_LAST = RING_W'(sbb_pkg::MAX_KERNEL - 1);

    t_state r_state;

    logic [DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [KER_W-1:0]  r_cfg_kw, r_cfg_kh;

    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [RING_W-1:0] r_in_ring;
    logic [RING_W-1:0] r_in_wmod;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [RING_W-1:0] r_out_ring;

    logic [sbb_pkg::PIX_W-1:0] r_win [sbb_pkg::MAX_KERNEL];

    logic [COL_W-1:0]  r_hc;
    logic [RING_W-1:0] r_hcmod;
    logic [RING_W-1:0] r_hring;
    logic              r_hend;
    logic [RING_W-1:0] r_idx;     // window slot or line ring row being summed
    logic signed [POS_W-1:0] r_pos;
    logic [KER_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic              r_rd_v;

    logic                      r_out_v;
    logic [sbb_pkg::PIX_W-1:0] r_out_pix;
    logic                      r_out_last;
    logic [sbb_pkg::PIX_W-1:0] r_res;
    logic                      r_res_last;

    // line store
    logic [sbb_pkg::PIX_W-1:0] r_line [sbb_pkg::LINE_DEPTH];
    logic [sbb_pkg::PIX_W-1:0] r_rdata;
    logic                      line_we;
    logic [sbb_pkg::LINE_AW-1:0] line_waddr, line_raddr;

    sbb_pkg::t_div_req div_req;
    sbb_pkg::t_div_rsp div_rsp;

    // effective geometry
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [COL_W-1:0]  wm1;
    logic [ROW_W-1:0]  hm1;
    logic [KER_W-1:0]  kw, kh;
    logic [sbb_pkg::HALF_W-1:0] pw, pv;

    always_comb begin
        if (r_cfg_w == '0)
            w_eff = DIM_W'(1);
        else if (r_cfg_w > DIM_W'(sbb_pkg::MAX_WIDTH))
            w_eff = DIM_W'(sbb_pkg::MAX_WIDTH);
        else
            w_eff = r_cfg_w;
        if (r_cfg_h == '0)
            h_eff = DIM_W'(1);
        else if (r_cfg_h > DIM_W'(sbb_pkg::MAX_HEIGHT))
            h_eff = DIM_W'(sbb_pkg::MAX_HEIGHT);
        else
            h_eff = r_cfg_h;
    end

    logic [DIM_W-1:0] w_m1_full, h_m1_full;
    assign w_m1_full = w_eff - 1'b1;
    assign h_m1_full = h_eff - 1'b1;
    assign wm1 = w_m1_full[COL_W-1:0];
    assign hm1 = ROW_W'(h_m1_full);
    assign kw  = r_cfg_kw | KER_W'(1);
    assign kh  = r_cfg_kh | KER_W'(1);
    assign pw  = kw[KER_W-1:1];
    assign pv  = kh[KER_W-1:1];

    // input side decode
    logic in_acc, is_px, row_end, past_half;
    logic [RING_W:0] wmod_diff, hmod_diff, vring_diff;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign is_px     = (s_axis_tuser == sbb_pkg::REQ_PIXEL) && (r_in_row < ROW_W'(h_eff));
    assign row_end   = r_in_col == wm1;
    assign past_half = r_in_col >= COL_W'(pw);
    assign wmod_diff = {1'b0, r_in_wmod} - {2'b00, pw};
    assign hmod_diff = {1'b0, r_hcmod} - {2'b00, pw};
    assign vring_diff = {1'b0, r_out_ring} - {2'b00, pv};

    logic signed [POS_W-1:0] hpos0, vrow0;
    assign hpos0 = $signed({2'b00, r_hc}) - $signed({{(POS_W-sbb_pkg::HALF_W){1'b0}}, pw});
    assign vrow0 = $signed({1'b0, r_out_row}) - $signed({{(POS_W-sbb_pkg::HALF_W){1'b0}}, pv});

    // completeness of the next output window
    logic [ROW_W-1:0] tr_raw, tr;
    logic [COL_W:0]   tc_raw, tc;
    logic             complete;
    assign tr_raw = r_out_row + ROW_W'(pv);
    assign tr     = (tr_raw > hm1) ? hm1 : tr_raw;
    assign tc_raw = {1'b0, r_out_col} + (COL_W+1)'(pw);
    assign tc     = (tc_raw > {1'b0, wm1}) ? {1'b0, wm1} : tc_raw;
    assign complete = (r_out_row < ROW_W'(h_eff)) &&
                      ((r_in_row > tr) || (r_in_row == tr && {1'b0, r_in_col} > tc));

    logic res_last;
    assign res_last = (r_out_row == hm1) && (r_out_col == wm1);

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

    assign div_req.start = (r_state == S_HGO) || (r_state == S_VGO);
    assign div_req.num   = r_sum;
    assign div_req.den   = (r_state == S_HGO) ? kw : kh;

    assign line_we    = (r_state == S_HDIV) && div_rsp.done;
    assign line_waddr = sbb_pkg::LINE_AW'({r_hring, r_hc});
    assign line_raddr = sbb_pkg::LINE_AW'({r_idx, r_out_col});

    sbb_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (line_we)
            r_line[line_waddr] <= div_rsp.quo;
        r_rdata <= r_line[line_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_w    <= DIM_W'(1024);
            r_cfg_h    <= DIM_W'(1024);
            r_cfg_kw   <= KER_W'(3);
            r_cfg_kh   <= KER_W'(3);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_ring  <= '0;
            r_in_wmod  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_ring <= '0;
            r_out_v    <= 1'b0;
            r_rd_v     <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_VRD);
            // S_PUT owns the output valid in its own cycle
            if (r_out_v && m_axis_tready && r_state != S_PUT)
                r_out_v <= 1'b0;
            if (r_rd_v)
                r_sum <= r_sum + SUM_W'(r_rdata);

            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (t_cfg_sel'(i_cfg_index))
                            sbb_pkg::REG_IMAGE_WIDTH:   r_cfg_w  <= i_cfg_data;
                            sbb_pkg::REG_IMAGE_HEIGHT:  r_cfg_h  <= i_cfg_data;
                            sbb_pkg::REG_KERNEL_WIDTH:  r_cfg_kw <= i_cfg_data[KER_W-1:0];
                            sbb_pkg::REG_KERNEL_HEIGHT: r_cfg_kh <= i_cfg_data[KER_W-1:0];
                            default: ;
                        endcase
                        r_in_col   <= '0;
                        r_in_row   <= '0;
                        r_in_ring  <= '0;
                        r_in_wmod  <= '0;
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                        r_out_ring <= '0;
                    end else if (in_acc) begin
                        r_state <= S_VCHECK;
                        if (is_px) begin
                            r_win[r_in_wmod] <= s_axis_tdata;
                            r_hring <= r_in_ring;
                            r_hend  <= row_end;
                            if (past_half) begin
                                r_hc    <= r_in_col - COL_W'(pw);
                                r_hcmod <= wmod_diff[RING_W] ?
                                           RING_W'(wmod_diff + (RING_W+1)'(sbb_pkg::MAX_KERNEL)) :
                                           wmod_diff[RING_W-1:0];
                            end else begin
                                r_hc    <= '0;
                                r_hcmod <= '0;
                            end
                            if (row_end || past_half)
                                r_state <= S_HSTART;
                            if (row_end) begin
                                r_in_col  <= '0;
                                r_in_wmod <= '0;
                                r_in_row  <= r_in_row + 1'b1;
                                r_in_ring <= (r_in_ring == RING_W'(kh - 1'b1)) ?
                                             '0 : r_in_ring + 1'b1;
                            end else begin
                                r_in_col  <= r_in_col + 1'b1;
                                r_in_wmod <= (r_in_wmod == WIN_LAST) ? '0 : r_in_wmod + 1'b1;
                            end
                        end
                    end
                end
                S_HSTART: begin
                    r_pos <= hpos0;
                    r_cnt <= '0;
                    r_sum <= '0;
                    if (hpos0 <= 0)
                        r_idx <= '0;
                    else
                        r_idx <= hmod_diff[RING_W] ?
                                 RING_W'(hmod_diff + (RING_W+1)'(sbb_pkg::MAX_KERNEL)) :
                                 hmod_diff[RING_W-1:0];
                    r_state <= S_HSUM;
                end
                S_HSUM: begin
                    r_sum <= r_sum + SUM_W'(r_win[r_idx]);
                    // slot follows the clamped position: hold before 0 and at the edge
                    if (r_pos >= 0 && r_pos < $signed({2'b00, wm1}))
                        r_idx <= (r_idx == WIN_LAST) ? '0 : r_idx + 1'b1;
                    r_pos <= r_pos + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == kw - 1'b1)
                        r_state <= S_HGO;
                end
                S_HGO: begin
                    r_state <= S_HDIV;
                end
                S_HDIV: begin
                    if (div_rsp.done) begin
                        if (r_hend && r_hc != wm1) begin
                            r_hc    <= r_hc + 1'b1;
                            r_hcmod <= (r_hcmod == WIN_LAST) ? '0 : r_hcmod + 1'b1;
                            r_state <= S_HSTART;
                        end else begin
                            r_state <= S_VCHECK;
                        end
                    end
                end
                S_VCHECK: begin
                    r_pos <= vrow0;
                    r_cnt <= '0;
                    r_sum <= '0;
                    if (vrow0 <= 0)
                        r_idx <= '0;
                    else
                        r_idx <= vring_diff[RING_W] ?
                                 RING_W'(vring_diff + (RING_W+1)'(kh)) :
                                 vring_diff[RING_W-1:0];
                    r_state <= complete ? S_VRD : S_IDLE;
                end
                S_VRD: begin
                    if (r_pos >= 0 && r_pos < $signed({1'b0, hm1}))
                        r_idx <= (r_idx == RING_W'(kh - 1'b1)) ? '0 : r_idx + 1'b1;
                    r_pos <= r_pos + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == kh - 1'b1)
                        r_state <= S_VLAST;
                end
                S_VLAST: begin
                    r_state <= S_VGO;
                end
                S_VGO: begin
                    r_state <= S_VDIV;
                end
                S_VDIV: begin
                    if (div_rsp.done) begin
                        r_res      <= div_rsp.quo;
                        r_res_last <= res_last;
                        r_state    <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_out_v || m_axis_tready) begin
                        r_out_v    <= 1'b1;
                        r_out_pix  <= r_res;
                        r_out_last <= r_res_last;
                        r_state    <= S_IDLE;
                        if (r_res_last) begin
                            r_in_col   <= '0;
                            r_in_row   <= '0;
                            r_in_ring  <= '0;
                            r_in_wmod  <= '0;
                            r_out_col  <= '0;
                            r_out_row  <= '0;
                            r_out_ring <= '0;
                        end else if (r_out_col == wm1) begin
                            r_out_col  <= '0;
                            r_out_row  <= r_out_row + 1'b1;
                            r_out_ring <= (r_out_ring == RING_W'(kh - 1'b1)) ?
                                          '0 : r_out_ring + 1'b1;
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/sbb_div.sv]
// ----------------------------------------------------------------------------
// sbb_div: restoring divider for window sums
// One quotient bit per cycle; done pulses once the last quotient bit is shifted in.
// ----------------------------------------------------------------------------
module sbb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbb_pkg::t_div_req i_req,
    output sbb_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(sbb_pkg::SUM_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [sbb_pkg::SUM_W-1:0]   r_num;
    logic [sbb_pkg::KER_W-1:0]   r_rem;
    logic [sbb_pkg::KER_W-1:0]   r_den;

    logic [sbb_pkg::KER_W:0]     trial;
    logic                        ge;
    logic [sbb_pkg::KER_W:0]     diff;

    assign trial = {r_rem, r_num[sbb_pkg::SUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? diff[sbb_pkg::KER_W-1:0] : trial[sbb_pkg::KER_W-1:0];
                r_num <= {r_num[sbb_pkg::SUM_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(sbb_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient never exceeds 255 since the sum holds at most divisor * 255
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num[sbb_pkg::PIX_W-1:0];

endmodule

[bench/sbb_checker.sv]
// ----------------------------------------------------------------------------
// sbb_checker: result predictor and scoreboard for separable_box_blur
// Watches the config, input and output channels, predicts every blurred pixel
// and compares the output stream against it in order.
// ----------------------------------------------------------------------------
module sbb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [sbb_pkg::PIX_W-1:0]     i_in_data,
    input  logic                          i_in_user,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [sbb_pkg::PIX_W-1:0]     i_out_data,
    input  logic                          i_out_last,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [sbb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbb_pkg::DIM_W-1:0]     i_cfg_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_frames
);

    localparam int PIX_W      = sbb_pkg::PIX_W;
    localparam int DIM_W      = sbb_pkg::DIM_W;
    localparam int KER_W      = sbb_pkg::KER_W;
    localparam int MAX_KERNEL = sbb_pkg::MAX_KERNEL;
    localparam int MAX_WIDTH  = sbb_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = sbb_pkg::MAX_HEIGHT;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } t_blur_px;

    t_blur_px         blur_q[$];
    logic [DIM_W-1:0] img_w, img_h;
    logic [KER_W-1:0] ker_w, ker_h;
    logic [PIX_W-1:0] row_win[MAX_KERNEL];
    logic [PIX_W-1:0] hline[MAX_KERNEL*MAX_WIDTH];
    int               in_col, in_row, out_col, out_row;

    function automatic int dim_clip(int v, int mx);
        if (v < 1) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic int kern_clip(logic [KER_W-1:0] k);
        int kk;
        kk = int'(k) | 1;
        return (kk > ((MAX_KERNEL - 1) | 1)) ? ((MAX_KERNEL - 1) | 1) : kk;
    endfunction

    function automatic int clip_hi(int v, int hi);
        if (v < 0) return 0;
        return (v > hi) ? hi : v;
    endfunction

    task automatic row_blur(int r, int c, int w, int kw, int kh);
        int sum;
        sum = 0;
        for (int d = 0; d < kw; d++)
            sum += row_win[clip_hi(c + d - kw / 2, w - 1) % MAX_KERNEL];
        hline[(r % kh) * MAX_WIDTH + c] = PIX_W'(sum / kw);
    endtask

    task automatic blur_step(logic kind, logic [PIX_W-1:0] px);
        int w, h, kw, kh, pw, pv, tr, tc, sum, c;
        t_blur_px res;
        w  = dim_clip(int'(img_w), MAX_WIDTH);
        h  = dim_clip(int'(img_h), MAX_HEIGHT);
        kw = kern_clip(ker_w);
        kh = kern_clip(ker_h);
        pw = kw / 2;
        pv = kh / 2;
        if (kind == sbb_pkg::REQ_PIXEL && in_row < h) begin
            row_win[in_col % MAX_KERNEL] = px;
            if (in_col == w - 1) begin
                for (c = (in_col >= pw) ? in_col - pw : 0; c < w; c++)
                    row_blur(in_row, c, w, kw, kh);
            end else if (in_col >= pw) begin
                row_blur(in_row, in_col - pw, w, kw, kh);
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row < h) begin
            tr = (out_row + pv > h - 1) ? h - 1 : out_row + pv;
            tc = (out_col + pw > w - 1) ? w - 1 : out_col + pw;
            if (in_row > tr || (in_row == tr && in_col > tc)) begin
                sum = 0;
                for (int d = 0; d < kh; d++)
                    sum += hline[(clip_hi(out_row + d - pv, h - 1) % kh) * MAX_WIDTH
                                 + out_col];
                res.pix  = PIX_W'(sum / kh);
                res.last = (out_row == h - 1) && (out_col == w - 1);
                blur_q.push_back(res);
                if (res.last) begin
                    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    o_frames++;
                end else begin
                    out_col++;
                    if (out_col >= w) begin
                        out_col = 0;
                        out_row++;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_blur_px want;
        if (!i_rst_n) begin
            img_w = 11'd1024; img_h = 11'd1024; ker_w = 5'd3; ker_h = 5'd3;
            for (int i = 0; i < MAX_KERNEL; i++) row_win[i] = '0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            blur_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (blur_q.size() == 0) begin
                    $display("%0t: unexpected output pix=%0d last=%0b",
                             $time, i_out_data, i_out_last);
                    o_errors++;
                end else begin
                    want = blur_q.pop_front();
                    if (want.pix !== i_out_data || want.last !== i_out_last) begin
                        $display("%0t: mismatch expected pix=%0d last=%0b, got pix=%0d last=%0b",
                                 $time, want.pix, want.last, i_out_data, i_out_last);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (sbb_pkg::t_cfg_reg'(i_cfg_index))
                    sbb_pkg::REG_IMAGE_WIDTH:   img_w = i_cfg_data;
                    sbb_pkg::REG_IMAGE_HEIGHT:  img_h = i_cfg_data;
                    sbb_pkg::REG_KERNEL_WIDTH:  ker_w = i_cfg_data[KER_W-1:0];
                    sbb_pkg::REG_KERNEL_HEIGHT: ker_h = i_cfg_data[KER_W-1:0];
                    default: ;
                endcase
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end
            if (i_in_valid && i_in_ready) blur_step(i_in_user, i_in_data);
        end
        o_pending = blur_q.size();
    end

endmodule

[bench/tb_separable_box_blur.sv]
// ----------------------------------------------------------------------------
// tb_separable_box_blur: stream test of the separable box blur
// Runs frames under many image and kernel sizes, directed then random, with
// bursty gaps on both stream sides; a checker predicts and compares outputs.
// ----------------------------------------------------------------------------
module tb_separable_box_blur;

    localparam int PIX_W       = sbb_pkg::PIX_W;
    localparam int DIM_W       = sbb_pkg::DIM_W;
    localparam int MAX_WIDTH   = sbb_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT  = sbb_pkg::MAX_HEIGHT;

    localparam int WDOG_LIMIT  = 50000;
    localparam int SETTLE      = 1000;
    localparam int ITEM_TARGET = 1700;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0, s_ready;
    logic [PIX_W-1:0]     s_data = '0;
    logic                 s_user = sbb_pkg::REQ_PIXEL;
    logic                 m_valid, m_ready = 1'b0, m_last;
    logic [PIX_W-1:0]     m_data;
    logic                 cfg_valid = 1'b0, cfg_ready;
    sbb_pkg::t_cfg_reg    cfg_index = sbb_pkg::REG_IMAGE_WIDTH;
    logic [DIM_W-1:0]     cfg_data = '0;
    int                   errors, pending, frames;
    int                   items = 0, wdog = 0;
    bit                   calm = 1'b0;
    int                   stall_left = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    separable_box_blur u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sbb_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready),
        .i_in_data(s_data), .i_in_user(s_user),
        .i_out_valid(m_valid), .i_out_ready(m_ready),
        .i_out_data(m_data), .i_out_last(m_last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_frames(frames)
    );

    // output side back-pressure in bursts
    always @(posedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rdy = 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 17);
            rdy = 1'b0;
        end
        m_ready <= rdy;
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("tb_separable_box_blur: FAIL");
            $finish;
        end
    end

    task automatic send_request(logic kind, logic [PIX_W-1:0] px);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= px;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        items++;
    endtask

    // idle the block, then write all four sizes
    task automatic set_sizes(int w, int h, int kw, int kh);
        logic [DIM_W-1:0] vals[4];
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        vals = '{DIM_W'(w), DIM_W'(h), DIM_W'(kw), DIM_W'(kh)};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= sbb_pkg::t_cfg_reg'(i);
            cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!cfg_ready) @(posedge i_clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // one frame: pixels (with drains mixed in unless directed), then drains (and stray pixels)
    task automatic run_frame(int w, int h, bit directed);
        int total, sent, snap;
        logic [PIX_W-1:0] pat[8];
        pat = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F};
        w = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        h = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        total = w * h;
        sent = 0;
        snap = frames;
        while (frames == snap) begin
            if (sent < total && (directed || $urandom_range(0, 7) != 0)) begin
                send_request(sbb_pkg::REQ_PIXEL,
                             directed ? pat[sent % 8] : PIX_W'($urandom_range(0, 255)));
                sent++;
            end else if (sent >= total && $urandom_range(0, 3) == 0) begin
                send_request(sbb_pkg::REQ_PIXEL, PIX_W'($urandom_range(0, 255)));
            end else begin
                send_request(sbb_pkg::REQ_DRAIN, PIX_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int w, h;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of sizes and kernels, corner pixel values
        set_sizes(4, 3, 3, 3);      run_frame(4, 3, 1'b1);
        set_sizes(1, 1, 1, 1);      run_frame(1, 1, 1'b1);
        set_sizes(0, 0, 0, 0);      run_frame(0, 0, 1'b1);
        set_sizes(3, 2, 31, 31);    run_frame(3, 2, 1'b1);
        set_sizes(5, 3, 2, 4);      run_frame(5, 3, 1'b0);
        // saturated width, long row; then tall single column
        set_sizes(2047, 1, 31, 30); run_frame(2047, 1, 1'b1);
        set_sizes(1, 40, 1, 31);    run_frame(1, 40, 1'b0);
        set_sizes(7, 5, 1, 5);      run_frame(7, 5, 1'b0); run_frame(7, 5, 1'b0);

        while (items < ITEM_TARGET) begin
            if (items > ITEM_TARGET - 300) calm = 1'b1;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
            set_sizes(w, h, $urandom_range(0, 31), $urandom_range(0, 31));
            repeat ($urandom_range(1, 2)) run_frame(w, h, 1'b0);
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb_separable_box_blur: PASS");
        else
            $display("tb_separable_box_blur: FAIL");
        $finish;
    end

endmodule
